// ===== hw/rtl/euler_to_rotation_matrix_defines.svh =====
// Assertion macros for the euler_to_rotation_matrix checker.
// No dependencies.
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define E2R_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define E2R_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/e2r_pkg.sv =====
// Shared constants, types and helpers for the Euler-to-rotation pipeline.
// No dependencies.
`default_nettype none
package e2r_pkg;
	localparam int OutFracBits = 30;
	localparam int CordicIter = 24;
	localparam int AngW = 26;
	localparam int OutW = 32;
	localparam int ZW = 34;   // CORDIC working width (Q30 with headroom)

	localparam logic signed [ZW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [ZW-1:0] OneQ30 = 34'sd1073741824;
	localparam logic signed [31:0] DegFull = 32'sd23592960;
	localparam logic signed [31:0] DegHalf = 32'sd11796480;
	localparam logic signed [31:0] DegQuarter = 32'sd5898240;
	// pi in Q32 is 45 * PiDiv45 + 15, and 180*2^18 is 45*2^20, so the radian value is
	// (mag*PiDiv45 + floor(mag/3) + 2^19) >> 20.
	localparam logic [28:0] PiDiv45 = 29'd299845282;
	// floor(mag/3) = (mag * Recip3) >> 25, exact for mag below 2^23.
	localparam logic [23:0] Recip3 = 24'd11184811;

	typedef logic signed [ZW-1:0] q30_t;

	typedef struct packed {
		q30_t s;
		q30_t c;
	} sincos_t;

	typedef struct packed {
		logic [AngW-1:0] x;
		logic [AngW-1:0] y;
		logic [AngW-1:0] z;
	} angles_t;

	typedef struct packed {
		logic [OutW-1:0] r00;
		logic [OutW-1:0] r01;
		logic [OutW-1:0] r02;
		logic [OutW-1:0] r10;
		logic [OutW-1:0] r11;
		logic [OutW-1:0] r12;
		logic [OutW-1:0] r20;
		logic [OutW-1:0] r21;
		logic [OutW-1:0] r22;
	} matrix_t;

	function automatic q30_t atan_q30(input int i);
		logic [31:0] t;
		begin
			unique case (i)
				0: t = 32'h3243F6A8; 1: t = 32'h1DAC6705; 2: t = 32'h0FADBAFC;
				3: t = 32'h07F56EA6; 4: t = 32'h03FEAB76; 5: t = 32'h01FFD55B;
				6: t = 32'h00FFFAAA; 7: t = 32'h007FFF55; 8: t = 32'h003FFFEA;
				9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
				12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
				15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
				18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
				21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
				24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
				27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
				30: t = 32'h00000001;
				default: t = 32'h0;
			endcase
			atan_q30 = q30_t'(t);
		end
	endfunction

	function automatic q30_t clamp_one(input logic signed [ZW+1:0] v);
		begin
			if (v > (ZW+2)'(OneQ30)) clamp_one = OneQ30;
			else if (v < -(ZW+2)'(OneQ30)) clamp_one = -OneQ30;
			else clamp_one = q30_t'(v);
		end
	endfunction

	// Round a Q60 product to Q30 (add half, floor).
	function automatic logic signed [ZW+1:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] t;
		begin
			t = p + 64'sd536870912;
			rnd30 = (ZW+2)'(t >>> 30);
		end
	endfunction

	function automatic logic [OutW-1:0] to_out(input q30_t v);
		logic signed [ZW:0] t;
		localparam int Sh = 30 - OutFracBits;
		begin
			t = {v[ZW-1], v};
			if (Sh > 0) t = (t + (ZW+1)'(1 << (Sh > 0 ? Sh - 1 : 0))) >>> Sh;
			to_out = OutW'(t);
		end
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/euler_to_rotation_matrix.sv =====
// Euler angles (Z-Y-X) to rotation matrix, fully pipelined.
// Input channel s_axis: tdata carries angle_x_deg [25:0], angle_y_deg [51:26],
// angle_z_deg [77:52], each degrees with 16 fractional bits; upper bits zero.
// Output channel m_axis: tdata carries r00..r22, 32 bits each from the lowest
// bit up, signed with 30 fractional bits.
// One item enters per cycle while the pipe advances. There are 4 register stages of
// angle reduction and radian conversion, 25 CORDIC stages (24 iterations plus
// clamp) and 3 matrix stages: 32 register stages, the last one being the output.
// The whole pipe advances as one: it moves when the output slot is empty or
// being taken, and freezes otherwise. s_axis_tready follows that enable, so
// a receiver stall holds every item in place and none is lost or repeated.
// Valid bits ride along each stage. Reset clears the valid bits only.
`default_nettype none
module euler_to_rotation_matrix import e2r_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,   // angle_x_deg, angle_y_deg, angle_z_deg
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [287:0]     m_axis_tdata    // r00,r01,r02,r10,r11,r12,r20,r21,r22
);
	localparam int Lat = 4 + CordicIter + 1 + 3;

	logic en;
	logic [Lat-1:0] vld_q;
	angles_t ang;
	q30_t zx, zy, zz;
	logic nx, ny, nz;
	sincos_t scx, scy, scz;
	matrix_t m;

	// Pipe moves when the last stage is empty or its item is being taken.
	assign en = !vld_q[Lat-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[Lat-1];

	always_comb begin
		ang.x = s_axis_tdata[25:0];
		ang.y = s_axis_tdata[51:26];
		ang.z = s_axis_tdata[77:52];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
		end
	end

	e2r_angle_prep u_px (.clk, .en, .ang(ang.x), .z(zx), .neg_cos(nx));
	e2r_angle_prep u_py (.clk, .en, .ang(ang.y), .z(zy), .neg_cos(ny));
	e2r_angle_prep u_pz (.clk, .en, .ang(ang.z), .z(zz), .neg_cos(nz));

	e2r_cordic u_cx (.clk, .en, .z_in(zx), .neg_in(nx), .sc(scx));
	e2r_cordic u_cy (.clk, .en, .z_in(zy), .neg_in(ny), .sc(scy));
	e2r_cordic u_cz (.clk, .en, .z_in(zz), .neg_in(nz), .sc(scz));

	e2r_matrix u_mat (.clk, .en, .scx, .scy, .scz, .m);

	assign m_axis_tdata = {m.r22, m.r21, m.r20, m.r12, m.r11, m.r10, m.r02, m.r01, m.r00};
endmodule
`default_nettype wire

// ===== hw/rtl/e2r_angle_prep.sv =====
// Angle reduction and degree-to-radian conversion for one angle, four stages.
// Depends on e2r_pkg.
`default_nettype none
module e2r_angle_prep import e2r_pkg::*; (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [AngW-1:0] ang,
	output q30_t                 z,
	output logic                 neg_cos
);
	// Stage 1: wrap to [-180,180). Input magnitude below 3*360 deg, so a few compares.
	logic signed [31:0] a, r1;
	logic signed [31:0] r_s1;
	always_comb begin
		a = 32'(signed'(ang));
		r1 = a;
		if (r1 >= DegFull + DegHalf) r1 = r1 - DegFull - DegFull;
		else if (r1 >= DegHalf) r1 = r1 - DegFull;
		else if (r1 < -DegFull - DegHalf) r1 = r1 + DegFull + DegFull;
		else if (r1 < -DegHalf) r1 = r1 + DegFull;
	end
	always_ff @(posedge clk) begin
		if (en) r_s1 <= r1;
	end

	// Stage 2: fold to [-90,90], take magnitude (below 2^23).
	logic signed [31:0] r2;
	logic nc2;
	logic [22:0] mag_s2;
	logic sgn_s2, nc_s2;
	always_comb begin
		r2 = r_s1;
		nc2 = 1'b0;
		if (r_s1 > DegQuarter) begin
			r2 = DegHalf - r_s1; nc2 = 1'b1;
		end else if (r_s1 < -DegQuarter) begin
			r2 = -DegHalf - r_s1; nc2 = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= r2[31] ? 23'(-r2) : 23'(r2);
			sgn_s2 <= r2[31];
			nc_s2 <= nc2;
		end
	end

	// Stage 3: mag * pi/45 (Q32) and mag/3 for the remainder term.
	logic [46:0] t3;
	logic [51:0] prod_s3;
	logic [21:0] third_s3;
	logic sgn_s3, nc_s3;
	always_comb t3 = 47'(mag_s2) * 47'(Recip3);
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= 52'(mag_s2) * 52'(PiDiv45);
			third_s3 <= t3[46:25];
			sgn_s3 <= sgn_s2;
			nc_s3 <= nc_s2;
		end
	end

	// Stage 4: add rounding half, drop 20 bits, restore sign.
	logic [51:0] sum4;
	always_comb sum4 = prod_s3 + 52'(third_s3) + 52'd524288;
	always_ff @(posedge clk) begin
		if (en) begin
			z <= sgn_s3 ? -q30_t'(sum4[51:20]) : q30_t'(sum4[51:20]);
			neg_cos <= nc_s3;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/e2r_cordic.sv =====
// Pipelined rotation-mode CORDIC, one register stage per iteration.
// Depends on e2r_pkg.
`default_nettype none
module e2r_cordic import e2r_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  q30_t      z_in,
	input  wire logic neg_in,
	output sincos_t   sc
);
	q30_t x_q [CordicIter+1];
	q30_t y_q [CordicIter+1];
	q30_t z_q [CordicIter+1];
	logic neg_q [CordicIter+1];

	always_comb begin
		x_q[0] = CordicGain;
		y_q[0] = '0;
		z_q[0] = z_in;
		neg_q[0] = neg_in;
	end

	for (genvar i = 0; i < CordicIter; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][ZW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_q30(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_q30(i);
				end
				neg_q[i+1] <= neg_q[i];
			end
		end
	end

	q30_t xc;
	always_comb xc = clamp_one((ZW+2)'(x_q[CordicIter]));
	always_ff @(posedge clk) begin
		if (en) begin
			sc.s <= clamp_one((ZW+2)'(y_q[CordicIter]));
			sc.c <= neg_q[CordicIter] ? -xc : xc;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/e2r_matrix.sv =====
// Matrix assembly from sines and cosines: two multiply stages and a sum stage.
// Depends on e2r_pkg.
`default_nettype none
module e2r_matrix import e2r_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  sincos_t   scx,
	input  sincos_t   scy,
	input  sincos_t   scz,
	output matrix_t   m
);
	function automatic logic signed [63:0] mul(input q30_t a, input q30_t b);
		mul = 64'(a) * 64'(b);
	endfunction

	// Stage A: first products.
	logic signed [63:0] czsy_a, szsy_a, czcy_a, szcy_a, szcx_a, szsx_a, czcx_a, czsx_a;
	logic signed [63:0] cysx_a, cycx_a;
	q30_t sx_a, cx_a, sy_a;
	always_ff @(posedge clk) begin
		if (en) begin
			czsy_a <= mul(scz.c, scy.s);
			szsy_a <= mul(scz.s, scy.s);
			czcy_a <= mul(scz.c, scy.c);
			szcy_a <= mul(scz.s, scy.c);
			szcx_a <= mul(scz.s, scx.c);
			szsx_a <= mul(scz.s, scx.s);
			czcx_a <= mul(scz.c, scx.c);
			czsx_a <= mul(scz.c, scx.s);
			cysx_a <= mul(scy.c, scx.s);
			cycx_a <= mul(scy.c, scx.c);
			sx_a <= scx.s;
			cx_a <= scx.c;
			sy_a <= scy.s;
		end
	end

	// Stage B: rounding, second products.
	logic signed [63:0] p01_b, p02_b, p11_b, p12_b;
	logic signed [ZW+1:0] t00_b, t10_b, szcx_b, szsx_b, czcx_b, czsx_b, t21_b, t22_b;
	q30_t sy_b;
	q30_t czsy_r, szsy_r;
	always_comb begin
		czsy_r = q30_t'(rnd30(czsy_a));
		szsy_r = q30_t'(rnd30(szsy_a));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p01_b <= mul(czsy_r, sx_a);
			p02_b <= mul(czsy_r, cx_a);
			p11_b <= mul(szsy_r, sx_a);
			p12_b <= mul(szsy_r, cx_a);
			t00_b <= rnd30(czcy_a);
			t10_b <= rnd30(szcy_a);
			szcx_b <= rnd30(szcx_a);
			szsx_b <= rnd30(szsx_a);
			czcx_b <= rnd30(czcx_a);
			czsx_b <= rnd30(czsx_a);
			t21_b <= rnd30(cysx_a);
			t22_b <= rnd30(cycx_a);
			sy_b <= sy_a;
		end
	end

	// Stage C: sums, clamps, output scaling.
	always_ff @(posedge clk) begin
		if (en) begin
			m.r00 <= to_out(clamp_one(t00_b));
			m.r01 <= to_out(clamp_one(rnd30(p01_b) - szcx_b));
			m.r02 <= to_out(clamp_one(rnd30(p02_b) + szsx_b));
			m.r10 <= to_out(clamp_one(t10_b));
			m.r11 <= to_out(clamp_one(rnd30(p11_b) + czcx_b));
			m.r12 <= to_out(clamp_one(rnd30(p12_b) - czsx_b));
			m.r20 <= to_out(clamp_one(-(ZW+2)'(sy_b)));
			m.r21 <= to_out(clamp_one(t21_b));
			m.r22 <= to_out(clamp_one(t22_b));
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/e2r_checker.sv =====
// Port-level checker for euler_to_rotation_matrix, bound to the top level.
// Depends on euler_to_rotation_matrix_defines.svh.
`default_nettype none
`include "euler_to_rotation_matrix_defines.svh"
module e2r_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [287:0] m_axis_tdata
);
	`E2R_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output stall not held")
	`E2R_ASSERT_IMP(a_rdy, clk, arst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked with free output")
	`E2R_ASSERT_IMP(a_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during stall")
	`E2R_ASSERT_IMP(a_r20, clk, arst_n, m_axis_tvalid, m_axis_tdata[223:192] != 32'h80000000, "r20 out of range")
endmodule
bind euler_to_rotation_matrix e2r_checker u_chk (.*);
`default_nettype wire

// ===== dv/euler_to_rotation_matrix_test.sv =====
// Self-checking bench for euler_to_rotation_matrix: angle triples in, Q1.30 matrices out.
// Depends on e2r_pkg and the euler_to_rotation_matrix RTL.
`default_nettype none
module euler_to_rotation_matrix_test;
	import e2r_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int RandomItems = 800;

	typedef struct {
		logic [25:0] ax;
		logic [25:0] ay;
		logic [25:0] az;
		bit          typed;    // expected matrix written in the row
		logic [31:0] m [9];
	} angle_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [79:0]  s_axis_tdata = '0;   // angle_x_deg, angle_y_deg, angle_z_deg
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [287:0] m_axis_tdata;        // r00, r01, r02, r10, r11, r12, r20, r21, r22

	int sender_idle_pct = 30;
	int receiver_idle_pct = 49;
	int failures = 0;
	int quiet_cycles = 0;

	logic [287:0] pending_matrices [$];

	euler_to_rotation_matrix dut (.*);

	always #1 clk = ~clk;

	// Arithmetic right shift of a 64-bit signed value.
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat_unit(longint v, longint one);
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return shr_floor(a * b + (64'sd1 << 29), 30);
	endfunction

	// Reduce, fold to [-90, 90], convert to radians and run the CORDIC.
	task automatic angle_sin_cos(input logic [25:0] raw, output longint s, output longint c);
		longint a, r, mag, z, x, y, dx, dy, t;
		bit flip;
		a = longint'(signed'(raw));
		flip = 1'b0;
		r = a % 23592960;
		if (r < 0) r += 23592960;
		if (r >= 11796480) r -= 23592960;
		if (r > 5898240) begin
			r = 11796480 - r;
			flip = 1'b1;
		end else if (r < -5898240) begin
			r = -11796480 - r;
			flip = 1'b1;
		end
		mag = r < 0 ? -r : r;
		mag = (mag * 64'sd13493037705 + 180 * (64'sd1 << 17)) / (180 * (64'sd1 << 18));
		z = r < 0 ? -mag : mag;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CordicIter; i++) begin
			t = longint'(atan_q30(i));
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= t;
			end else begin
				x += dx; y -= dy; z += t;
			end
		end
		x = sat_unit(x, 64'sd1 << 30);
		y = sat_unit(y, 64'sd1 << 30);
		s = y;
		c = flip ? -x : x;
	endtask

	function automatic logic [31:0] q30_to_port(longint v);
		int sh;
		sh = 30 - OutFracBits;
		v = sat_unit(v, 64'sd1 << 30);
		if (sh > 0) v = shr_floor(v + (64'sd1 << (sh - 1)), sh);
		v = sat_unit(v, 64'sd1 << OutFracBits);
		return v[31:0];
	endfunction

	// Rotation matrix R = Rz*Ry*Rx, packed r00 in the lowest bits.
	task automatic rotation_matrix(input logic [25:0] ax, ay, az, output logic [287:0] m);
		longint sx, cx, sy, cy, sz, cz, czsy, szsy;
		angle_sin_cos(ax, sx, cx);
		angle_sin_cos(ay, sy, cy);
		angle_sin_cos(az, sz, cz);
		czsy = qmul(cz, sy);
		szsy = qmul(sz, sy);
		m[31:0]    = q30_to_port(qmul(cz, cy));
		m[63:32]   = q30_to_port(qmul(czsy, sx) - qmul(sz, cx));
		m[95:64]   = q30_to_port(qmul(czsy, cx) + qmul(sz, sx));
		m[127:96]  = q30_to_port(qmul(sz, cy));
		m[159:128] = q30_to_port(qmul(szsy, sx) + qmul(cz, cx));
		m[191:160] = q30_to_port(qmul(szsy, cx) - qmul(cz, sx));
		m[223:192] = q30_to_port(-sy);
		m[255:224] = q30_to_port(qmul(cy, sx));
		m[287:256] = q30_to_port(qmul(cy, cx));
	endtask

	// Hand one item to the block and queue its expected matrix.
	// tvalid stays high after the handshake; it drops only while idling.
	task automatic send_angles(input logic [25:0] ax, ay, az, input bit typed,
			input logic [287:0] typed_m);
		logic [287:0] m;
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		rotation_matrix(ax, ay, az, m);
		if (typed && m !== typed_m) begin
			$error("table row disagrees with predictor: %h vs %h", typed_m, m);
			failures++;
		end
		pending_matrices = {pending_matrices, (typed ? typed_m : m)};
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, az, ay, ax};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Angle with mostly in-range values, some near multiples of 90 degrees, some over the full 26-bit range.
	function automatic logic [25:0] rand_angle();
		case ($urandom_range(9))
			0: return 26'($urandom);
			1: return 26'(($urandom_range(8) - 4) * 5898240 + $urandom_range(4) - 2);
			default: return 26'(int'($urandom_range(47185920)) - 23592960);
		endcase
	endfunction

	// Receiver: random stall, then compare with the oldest expectation.
	always @(posedge clk) begin
		m_axis_tready <= !(receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_matrices.size() == 0) begin
				$error("matrix with no item outstanding: %h", m_axis_tdata);
				failures++;
			end else begin
				logic [287:0] want;
				want = pending_matrices.pop_front();
				for (int k = 0; k < 9; k++)
					if (m_axis_tdata[32*k +: 32] !== want[32*k +: 32]) begin
						$error("r%0d%0d: expected %h actual %h", k / 3, k % 3,
							want[32*k +: 32], m_axis_tdata[32*k +: 32]);
						failures++;
					end
			end
		end
	end

	// Watchdog on cycles with no item moving on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		angle_row_t rows [$];
		angle_row_t row;
		logic [287:0] tm;

		// Zero angles: near identity, CORDIC residue leaves a few LSBs.
		row = '{26'd0, 26'd0, 26'd0, 1'b0, '{default: 0}};
		rows = {rows, row};
		// Extremes, exact quarter turns, obtuse folds, wraps beyond 360.
		begin
			logic [25:0] edge_vals [14];
			edge_vals = '{26'h1FF_FFFF, 26'h200_0000, 26'd23592960, -26'd23592960,
				26'd5898240, -26'd5898240, 26'd11796480, -26'd11796480,
				26'd5898241, -26'd5898241, 26'd8847360, -26'd8847360, 26'd1, -26'd1};
			for (int i = 0; i < 14; i++) begin
				row = '{edge_vals[i], edge_vals[(i + 5) % 14], edge_vals[(i + 9) % 14],
					1'b0, '{default: 0}};
				rows = {rows, row};
			end
		end
		for (int i = 0; i < 6; i++) begin
			row = '{rand_angle(), rand_angle(), rand_angle(), 1'b0, '{default: 0}};
			rows = {rows, row};
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			for (int k = 0; k < 9; k++) tm[32*k +: 32] = rows[i].m[k];
			send_angles(rows[i].ax, rows[i].ay, rows[i].az, rows[i].typed, tm);
		end
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = phase == 0 ? 30 : (phase == 1 ? 49 : 0);
			receiver_idle_pct = phase == 0 ? 49 : (phase == 1 ? 30 : 0);
			for (int n = 0; n < RandomItems / 3; n++)
				send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_matrices.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/e2r_pkg.sv
hw/rtl/e2r_angle_prep.sv
hw/rtl/e2r_cordic.sv
hw/rtl/e2r_matrix.sv
hw/rtl/euler_to_rotation_matrix.sv
hw/rtl/e2r_checker.sv
dv/euler_to_rotation_matrix_test.sv
